### sv/tedu_pkg.sv
// Shared types and constants for the TSP edge distance unit.
// Metric codes, result width and the per-item side-band struct.
// No dependencies.
package tedu_pkg;

   localparam int DIST_WIDTH   = 26;
   localparam int METRIC_WIDTH = 3;
   localparam int ATT_SCALE    = 10;

   localparam logic [METRIC_WIDTH-1:0] MET_EUC_ROUND = 3'd0;
   localparam logic [METRIC_WIDTH-1:0] MET_EUC_CEIL  = 3'd1;
   localparam logic [METRIC_WIDTH-1:0] MET_ATT       = 3'd2;
   localparam logic [METRIC_WIDTH-1:0] MET_MAX_NORM  = 3'd3;
   localparam logic [METRIC_WIDTH-1:0] MET_MANHATTAN = 3'd4;

   localparam logic [DIST_WIDTH-1:0] DIST_LIMIT = '1;

   // Travels with each transaction through the square-root stages
   typedef struct packed {
      logic [METRIC_WIDTH-1:0] metric;
      logic                    zero;    // sum of squares is zero
      logic [DIST_WIDTH-1:0]   simple;  // finished max-norm or Manhattan weight
   } tedu_side_type;

endpackage

### sv/tsp_edge_distance_unit_core.sv
// Top level of the TSP edge distance unit: abs differences, split squares,
// radicand select, pipelined square root and final rounding.
// Depends on tedu_pkg and tedu_root_step.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------
//   req     | in        | req_valid/stall   | req_ax, req_ay, req_bx, req_by
//   rsp     | out       | rsp_valid/stall   | rsp_distance
//   csr     | in        | csr_valid/ready   | csr_metric
//
// One transaction per cycle while rsp is not stalled. A result passes through
// five front stages (the first loads on the edge that accepts its
// transaction), one square-root stage per root bit (COORD_WIDTH+2 of them),
// and the output register, COORD_WIDTH+8 register loads in all.
// Reset is synchronous and clears all valid bits and sets the metric to 0.
// A stall on rsp backs up only as far as the first empty stage; req_stall
// rises only when every stage holds a transaction.
module tsp_edge_distance_unit_core
   import tedu_pkg::*;
#(
   parameter int COORD_WIDTH     = 32,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIST_WIDTH-1:0]         rsp_distance,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [METRIC_WIDTH-1:0]       csr_metric
);

   localparam int CW           = COORD_WIDTH;
   localparam int FB           = COORD_FRAC_BITS;
   localparam int LO_WIDTH     = (CW + 1) / 2;
   localparam int HI_WIDTH     = CW - LO_WIDTH;
   localparam int PLL_WIDTH    = 2 * LO_WIDTH;
   localparam int PHL_WIDTH    = HI_WIDTH + LO_WIDTH;
   localparam int PHH_WIDTH    = 2 * HI_WIDTH;
   localparam int SQ_WIDTH     = 2 * CW;
   localparam int SUM_WIDTH    = 2 * CW + 1;
   localparam int ROOT_WIDTH   = CW + 2;
   localparam int RAD_WIDTH    = 2 * ROOT_WIDTH;
   localparam int SCALED_WIDTH = ROOT_WIDTH + 4;
   localparam int PRE_WIDTH    = CW + 2;
   localparam int SX_WIDTH     = (CW + 3 > DIST_WIDTH + 1) ? CW + 3 : DIST_WIDTH + 1;
   localparam int FIN_WIDTH    = (ROOT_WIDTH + 1 > DIST_WIDTH + 1) ? ROOT_WIDTH + 1
                                                                    : DIST_WIDTH + 1;

   logic [METRIC_WIDTH-1:0] metric_ff;

   // stage 1: absolute differences
   logic                    s1_adv;
   logic [CW:0]             dx_ab, dx_ba, dy_ab, dy_ba;
   logic [CW-1:0]           dx_in, dy_in;
   logic                    s1_valid_ff;
   logic [METRIC_WIDTH-1:0] s1_metric_ff;
   logic [CW-1:0]           s1_dx_ff, s1_dy_ff;

   // stage 2: partial products
   logic                    s2_adv;
   logic [LO_WIDTH-1:0]     xlo, ylo;
   logic [HI_WIDTH-1:0]     xhi, yhi;
   logic [CW-1:0]           dmax;
   logic [CW:0]             dsum;
   logic [PRE_WIDTH-1:0]    pre_in;
   logic                    s2_valid_ff;
   logic [METRIC_WIDTH-1:0] s2_metric_ff;
   logic [PLL_WIDTH-1:0]    s2_xll_ff, s2_yll_ff;
   logic [PHL_WIDTH-1:0]    s2_xhl_ff, s2_yhl_ff;
   logic [PHH_WIDTH-1:0]    s2_xhh_ff, s2_yhh_ff;
   logic [PRE_WIDTH-1:0]    s2_pre_ff;

   // stage 3: squares
   logic                    s3_adv;
   logic                    s3_valid_ff;
   logic [METRIC_WIDTH-1:0] s3_metric_ff;
   logic [SQ_WIDTH-1:0]     s3_sqx_ff, s3_sqy_ff;
   logic [SX_WIDTH-1:0]     s3_simple_ff;

   // stage 4: sum of squares
   logic                    s4_adv;
   logic                    s4_valid_ff;
   logic [METRIC_WIDTH-1:0] s4_metric_ff;
   logic [SUM_WIDTH-1:0]    s4_sum_ff;
   logic [DIST_WIDTH-1:0]   s4_simple_ff;

   // stage 5: radicand
   logic                    s5_adv;
   logic                    sum_zero;
   logic [RAD_WIDTH-1:0]    rad_in;
   logic                    s5_valid_ff;
   tedu_side_type           s5_side_ff;
   logic [RAD_WIDTH-1:0]    s5_rad_ff;

   // square-root chain; index 0 is stage 5, index j+1 the output of step j
   logic                    rt_adv    [ROOT_WIDTH+1];
   logic                    rt_valid  [ROOT_WIDTH+1];
   tedu_side_type           rt_side   [ROOT_WIDTH+1];
   logic [RAD_WIDTH-1:0]    rt_rem    [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0]   rt_root   [ROOT_WIDTH+1];
   logic [SCALED_WIDTH-1:0] rt_scaled [ROOT_WIDTH+1];

   // output
   logic                    out_adv;
   tedu_side_type           fin_side;
   logic [ROOT_WIDTH-1:0]   fin_root;
   logic                    fin_inexact;
   logic [FIN_WIDTH-1:0]    fin_weight;
   logic [DIST_WIDTH-1:0]   dist_in;
   logic                    rsp_valid_ff;
   logic [DIST_WIDTH-1:0]   rsp_distance_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= MET_EUC_ROUND;
      end else if (csr_valid) begin
         metric_ff <= csr_metric;
      end
   end

   // advance a stage when it is empty or the next one advances
   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign s5_adv    = !s5_valid_ff || rt_adv[0];
   assign s4_adv    = !s4_valid_ff || s5_adv;
   assign s3_adv    = !s3_valid_ff || s4_adv;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   // ---- stage 1 ----
   always_comb begin
      dx_ab = {req_ax[CW-1], req_ax} - {req_bx[CW-1], req_bx};
      dx_ba = {req_bx[CW-1], req_bx} - {req_ax[CW-1], req_ax};
      dy_ab = {req_ay[CW-1], req_ay} - {req_by[CW-1], req_by};
      dy_ba = {req_by[CW-1], req_by} - {req_ay[CW-1], req_ay};
      dx_in = dx_ab[CW] ? dx_ba[CW-1:0] : dx_ab[CW-1:0];
      dy_in = dy_ab[CW] ? dy_ba[CW-1:0] : dy_ab[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_metric_ff <= metric_ff;
         s1_dx_ff     <= dx_in;
         s1_dy_ff     <= dy_in;
      end
   end

   // ---- stage 2 ----
   always_comb begin
      xlo  = s1_dx_ff[LO_WIDTH-1:0];
      xhi  = s1_dx_ff[CW-1:LO_WIDTH];
      ylo  = s1_dy_ff[LO_WIDTH-1:0];
      yhi  = s1_dy_ff[CW-1:LO_WIDTH];
      dmax = (s1_dx_ff < s1_dy_ff) ? s1_dy_ff : s1_dx_ff;
      dsum = {1'b0, s1_dx_ff} + {1'b0, s1_dy_ff};
      if (s1_metric_ff == MET_MAX_NORM) begin
         pre_in = {1'b0, dmax, 1'b0};
      end else begin
         pre_in = {dsum, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_metric_ff <= s1_metric_ff;
         s2_xll_ff    <= PLL_WIDTH'(xlo) * PLL_WIDTH'(xlo);
         s2_xhl_ff    <= PHL_WIDTH'(xhi) * PHL_WIDTH'(xlo);
         s2_xhh_ff    <= PHH_WIDTH'(xhi) * PHH_WIDTH'(xhi);
         s2_yll_ff    <= PLL_WIDTH'(ylo) * PLL_WIDTH'(ylo);
         s2_yhl_ff    <= PHL_WIDTH'(yhi) * PHL_WIDTH'(ylo);
         s2_yhh_ff    <= PHH_WIDTH'(yhi) * PHH_WIDTH'(yhi);
         s2_pre_ff    <= pre_in;
      end
   end

   // ---- stage 3 ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // d^2 = hi^2 * 2^(2L) + 2*hi*lo * 2^L + lo^2
   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_metric_ff <= s2_metric_ff;
         s3_sqx_ff    <= (SQ_WIDTH'(s2_xhh_ff) << (2 * LO_WIDTH))
                       + (SQ_WIDTH'(s2_xhl_ff) << (LO_WIDTH + 1))
                       + SQ_WIDTH'(s2_xll_ff);
         s3_sqy_ff    <= (SQ_WIDTH'(s2_yhh_ff) << (2 * LO_WIDTH))
                       + (SQ_WIDTH'(s2_yhl_ff) << (LO_WIDTH + 1))
                       + SQ_WIDTH'(s2_yll_ff);
         s3_simple_ff <= (SX_WIDTH'(s2_pre_ff) + (SX_WIDTH'(1) << FB)) >> (FB + 1);
      end
   end

   // ---- stage 4 ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_metric_ff <= s3_metric_ff;
         s4_sum_ff    <= SUM_WIDTH'(s3_sqx_ff) + SUM_WIDTH'(s3_sqy_ff);
         s4_simple_ff <= (s3_simple_ff > SX_WIDTH'(DIST_LIMIT))
                         ? DIST_LIMIT : s3_simple_ff[DIST_WIDTH-1:0];
      end
   end

   // ---- stage 5 ----
   // round takes the root of 4s; ATT searches the largest v with 10*v^2 <= s-1
   always_comb begin
      sum_zero = (s4_sum_ff == '0);
      case (s4_metric_ff)
         MET_EUC_ROUND: begin
            rad_in = RAD_WIDTH'(s4_sum_ff) << 2;
         end
         MET_ATT: begin
            rad_in = sum_zero ? '0 : RAD_WIDTH'(s4_sum_ff) - RAD_WIDTH'(1);
         end
         MET_EUC_CEIL, MET_MAX_NORM, MET_MANHATTAN: begin
            rad_in = RAD_WIDTH'(s4_sum_ff);
         end
         default: begin
            rad_in = RAD_WIDTH'(s4_sum_ff) << 2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_adv) begin
         s5_side_ff.metric <= s4_metric_ff;
         s5_side_ff.zero   <= sum_zero;
         s5_side_ff.simple <= s4_simple_ff;
         s5_rad_ff         <= rad_in;
      end
   end

   // ---- square root, one bit per stage, MSB first ----
   assign rt_valid[0]  = s5_valid_ff;
   assign rt_side[0]   = s5_side_ff;
   assign rt_rem[0]    = s5_rad_ff;
   assign rt_root[0]   = '0;
   assign rt_scaled[0] = '0;
   assign rt_adv[ROOT_WIDTH] = out_adv;

   for (genvar gi = 0; gi < ROOT_WIDTH; gi++) begin : g_root
      tedu_root_step #(
         .ROOT_WIDTH (ROOT_WIDTH),
         .BIT_INDEX  (ROOT_WIDTH - 1 - gi)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .load       (rt_adv[gi]),
         .in_valid   (rt_valid[gi]),
         .in_side    (rt_side[gi]),
         .in_rem     (rt_rem[gi]),
         .in_root    (rt_root[gi]),
         .in_scaled  (rt_scaled[gi]),
         .out_valid  (rt_valid[gi+1]),
         .out_side   (rt_side[gi+1]),
         .out_rem    (rt_rem[gi+1]),
         .out_root   (rt_root[gi+1]),
         .out_scaled (rt_scaled[gi+1])
      );
      assign rt_adv[gi] = !rt_valid[gi+1] || rt_adv[gi+1];
   end

   // ---- final rounding and output register ----
   always_comb begin
      fin_side    = rt_side[ROOT_WIDTH];
      fin_root    = rt_root[ROOT_WIDTH];
      fin_inexact = |rt_rem[ROOT_WIDTH];
      case (fin_side.metric)
         MET_EUC_CEIL: begin
            // ceil of root, then ceil of the fraction shift, in one add
            fin_weight = (FIN_WIDTH'(fin_root)
                       + (fin_inexact ? (FIN_WIDTH'(1) << FB)
                                      : (FIN_WIDTH'(1) << FB) - FIN_WIDTH'(1))) >> FB;
         end
         MET_ATT: begin
            fin_weight = fin_side.zero ? '0
                       : (FIN_WIDTH'(fin_root) + (FIN_WIDTH'(1) << FB)) >> FB;
         end
         MET_MAX_NORM, MET_MANHATTAN: begin
            fin_weight = FIN_WIDTH'(fin_side.simple);
         end
         default: begin
            fin_weight = (FIN_WIDTH'(fin_root) + (FIN_WIDTH'(1) << FB)) >> (FB + 1);
         end
      endcase
      dist_in = (fin_weight > FIN_WIDTH'(DIST_LIMIT)) ? DIST_LIMIT
                                                      : fin_weight[DIST_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= rt_valid[ROOT_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_distance_ff <= dist_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

### sv/tedu_root_step.sv
// One digit stage of the pipelined integer square root.
// Settles root bit BIT_INDEX; scales the trial by ten for the ATT metric.
// Depends on tedu_pkg.
module tedu_root_step
   import tedu_pkg::*;
#(
   parameter int ROOT_WIDTH = 34,
   parameter int BIT_INDEX  = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      in_valid,
   input  tedu_side_type             in_side,
   input  logic [2*ROOT_WIDTH-1:0]   in_rem,
   input  logic [ROOT_WIDTH-1:0]     in_root,
   input  logic [ROOT_WIDTH+3:0]     in_scaled,
   output logic                      out_valid,
   output tedu_side_type             out_side,
   output logic [2*ROOT_WIDTH-1:0]   out_rem,
   output logic [ROOT_WIDTH-1:0]     out_root,
   output logic [ROOT_WIDTH+3:0]     out_scaled
);

   localparam int RAD_WIDTH    = 2 * ROOT_WIDTH;
   localparam int SCALED_WIDTH = ROOT_WIDTH + 4;
   localparam int TRIAL_WIDTH  = RAD_WIDTH + 5;

   logic                    att;
   logic [TRIAL_WIDTH-1:0]  trial;
   logic [TRIAL_WIDTH:0]    diff;
   logic                    take;
   logic [RAD_WIDTH-1:0]    rem_in;
   logic [ROOT_WIDTH-1:0]   root_in;
   logic [SCALED_WIDTH-1:0] scaled_in;

   logic                    valid_ff;
   tedu_side_type           side_ff;
   logic [RAD_WIDTH-1:0]    rem_ff;
   logic [ROOT_WIDTH-1:0]   root_ff;
   logic [SCALED_WIDTH-1:0] scaled_ff;

   // scaled holds k*root, k = 1 or 10; trial = k*((root+b)^2 - root^2)
   always_comb begin
      att   = (in_side.metric == MET_ATT);
      trial = (TRIAL_WIDTH'(in_scaled) << (BIT_INDEX + 1))
            + (att ? (TRIAL_WIDTH'(ATT_SCALE) << (2 * BIT_INDEX))
                   : (TRIAL_WIDTH'(1) << (2 * BIT_INDEX)));
      diff  = {1'b0, TRIAL_WIDTH'(in_rem)} - {1'b0, trial};
      take  = !diff[TRIAL_WIDTH];
      if (take) begin
         rem_in    = diff[RAD_WIDTH-1:0];
         root_in   = in_root | (ROOT_WIDTH'(1) << BIT_INDEX);
         scaled_in = in_scaled
                   + (att ? (SCALED_WIDTH'(ATT_SCALE) << BIT_INDEX)
                          : (SCALED_WIDTH'(1) << BIT_INDEX));
      end else begin
         rem_in    = in_rem;
         root_in   = in_root;
         scaled_in = in_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff   <= in_side;
         rem_ff    <= rem_in;
         root_ff   <= root_in;
         scaled_ff <= scaled_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_side   = side_ff;
   assign out_rem    = rem_ff;
   assign out_root   = root_ff;
   assign out_scaled = scaled_ff;

endmodule

### sv/tedu_checker.sv
// Port-level checks for tsp_edge_distance_unit_core, attached by bind.
// Depends on tedu_pkg and the top level's port names.
module tedu_checker
   import tedu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DIST_WIDTH-1:0] rsp_distance
);

   localparam int CNT_WIDTH = 16;

   logic [CNT_WIDTH-1:0] outstanding_ff;
   logic [CNT_WIDTH-1:0] outstanding_in;

   // count transactions accepted but not yet delivered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_valid && !req_stall) begin
         outstanding_in = outstanding_in + CNT_WIDTH'(1);
      end
      if (rsp_valid && !rsp_stall) begin
         outstanding_in = outstanding_in - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req_stall high while output register can move");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance)))
      else $error("stalled rsp transaction changed or dropped");

   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("rsp transaction without an accepted req transaction");

endmodule

bind tsp_edge_distance_unit_core tedu_checker u_tedu_checker (.*);
